FILE: rtl/vrt_pkg.sv
package vrt_pkg;

  localparam int PW = 52;
  localparam int EW = 53;

  localparam logic [EW-1:0] PAGE_LIMIT = 53'h10000000000000;
  localparam logic [PW-1:0] ARENA_LO_RESET = 52'hFFFFC00000000;
  localparam logic [PW-1:0] ARENA_HI_RESET = 52'hFFFFE00000000;

  localparam logic [2:0] ACT_INSERT  = 3'd0;
  localparam logic [2:0] ACT_ALLOC   = 3'd1;
  localparam logic [2:0] ACT_LOOKUP  = 3'd2;
  localparam logic [2:0] ACT_REMOVE  = 3'd3;
  localparam logic [2:0] ACT_SETPROT = 3'd4;
  localparam logic [2:0] ACT_RANGE   = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERLAP  = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_INVALID  = 3'd5;

  localparam logic [1:0] CFG_ARENA_LO = 2'd0;
  localparam logic [1:0] CFG_ARENA_HI = 2'd1;
  localparam logic [1:0] CFG_NEAR_LO  = 2'd2;
  localparam logic [1:0] CFG_NEAR_HI  = 2'd3;

  localparam logic [1:0] SRC_NONE       = 2'd0;
  localparam logic [1:0] SRC_KEY        = 2'd1;
  localparam logic [1:0] SRC_ENTRY      = 2'd2;
  localparam logic [1:0] SRC_ENTRY_PROT = 2'd3;

  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_PREV = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;

  typedef struct packed {
    logic       ga;
    logic       gb;
    logic       kind;
    logic [2:0] prot;
  } attr_t;

  typedef struct packed {
    logic [PW-1:0] base;
    logic [PW-1:0] pages;
    attr_t         attr;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic       idle;
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       idx_dec;
    logic       idx_count;
    logic       pos_init;
    logic       pos_take;
    logic       cur_win;
    logic       cur_addr;
    logic       cur_gap;
    logic       cur_rend;
    logic       key_cur;
    logic       rd;
    logic [1:0] rd_sel;
    logic       wr_shift;
    logic       wr_new;
    logic       wr_prot;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_wr;
    logic [2:0] res_status;
    logic       res_hit;
    logic [1:0] res_src;
    logic       res_svc;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] action;
    logic       pre_bad;
    logic       full;
    logic       cnt_zero;
    logic       idx_at_count;
    logic       idx_at_pos;
    logic       idx_last;
    logic       ovl;
    logic       base_gt;
    logic       base_eq;
    logic       in_region;
    logic       gap_below;
    logic       gap_above;
    logic       gap_fit;
    logic       tail_fit;
    logic       rng_behind;
    logic       rng_hole;
    logic       rng_prot_ok;
    logic       rng_done;
    logic       out_free;
  } st_t;

endpackage

FILE: rtl/vrt_if.sv
interface vrt_req_if import vrt_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [2:0]    action;
  logic [PW-1:0] page_addr;
  logic [PW-1:0] page_count;
  logic [2:0]    prot;
  logic          region_kind;
  logic          guard_below;
  logic          guard_above;
  logic          near_window;
  logic [1:0]    access_kind;
  logic          fault_present;

  modport source (output valid, action, page_addr, page_count, prot, region_kind,
                  guard_below, guard_above, near_window, access_kind, fault_present,
                  input ready);
  modport sink (input valid, action, page_addr, page_count, prot, region_kind,
                guard_below, guard_above, near_window, access_kind, fault_present,
                output ready);
endinterface

interface vrt_rsp_if import vrt_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic          hit;
  logic [PW-1:0] region_base;
  logic [PW-1:0] region_pages;
  logic [2:0]    region_prot;
  logic          found_kind;
  logic          service_fault;

  modport source (output valid, status, hit, region_base, region_pages, region_prot,
                  found_kind, service_fault, input ready);
  modport sink (input valid, status, hit, region_base, region_pages, region_prot,
                found_kind, service_fault, output ready);
endinterface

interface vrt_cfg_if import vrt_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [1:0]    index;
  logic [PW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/vrt_ram.sv
module vrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/vrt_ctrl.sv
module vrt_ctrl import vrt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  st_t  st,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_SUR   = 4'd4;
  localparam logic [3:0] S_SUW   = 4'd5;
  localparam logic [3:0] S_SDR   = 4'd6;
  localparam logic [3:0] S_SDW   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  localparam logic [2:0] M_OVL   = 3'd0;
  localparam logic [2:0] M_GAP   = 3'd1;
  localparam logic [2:0] M_LOOK  = 3'd2;
  localparam logic [2:0] M_EXACT = 3'd3;
  localparam logic [2:0] M_RANGE = 3'd4;

  logic [3:0] state, state_next;
  logic [2:0] mode, mode_next;
  logic       tail;
  logic       found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= M_OVL;
    end else begin
      state <= state_next;
      mode <= mode_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    mode_next = mode;
    tail = 1'b0;
    found = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (st.in_valid) begin
          cmd.load = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.idx_clr = 1'b1;
        state_next = S_RD;
        case (st.action)
          ACT_INSERT: begin
            cmd.pos_init = 1'b1;
            mode_next = M_OVL;
            if (st.pre_bad) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_INVALID;
              state_next = S_FIN;
            end else if (st.full) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_FULL;
              state_next = S_FIN;
            end
          end
          ACT_ALLOC: begin
            cmd.cur_win = 1'b1;
            mode_next = M_GAP;
            if (st.pre_bad) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_INVALID;
              state_next = S_FIN;
            end
          end
          ACT_LOOKUP: begin
            mode_next = M_LOOK;
          end
          ACT_REMOVE: begin
            mode_next = M_EXACT;
          end
          ACT_SETPROT: begin
            mode_next = M_EXACT;
            if (st.pre_bad) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_INVALID;
              state_next = S_FIN;
            end
          end
          ACT_RANGE: begin
            cmd.cur_addr = 1'b1;
            mode_next = M_RANGE;
            if (st.cnt_zero) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_OK;
              cmd.res_hit = 1'b1;
              state_next = S_FIN;
            end
          end
          default: begin
            cmd.res_wr = 1'b1;
            cmd.res_status = ST_INVALID;
            state_next = S_FIN;
          end
        endcase
      end
      S_RD: begin
        if (st.idx_at_count) begin
          case (mode)
            M_OVL: begin
              cmd.idx_count = 1'b1;
              state_next = S_SUR;
            end
            M_GAP: begin
              tail = 1'b1;
            end
            M_RANGE: begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_OK;
              state_next = S_FIN;
            end
            default: begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_next = S_FIN;
            end
          endcase
        end else begin
          cmd.rd = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (mode)
          M_OVL: begin
            if (st.ovl) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_OVERLAP;
              state_next = S_FIN;
            end else begin
              cmd.pos_take = st.base_gt;
              cmd.idx_inc = 1'b1;
              state_next = S_RD;
            end
          end
          M_GAP: begin
            if (st.gap_below) begin
              cmd.idx_inc = 1'b1;
              state_next = S_RD;
            end else if (st.gap_above) begin
              tail = 1'b1;
            end else if (st.gap_fit) begin
              found = 1'b1;
            end else begin
              cmd.cur_gap = 1'b1;
              cmd.idx_inc = 1'b1;
              state_next = S_RD;
            end
          end
          M_LOOK: begin
            if (st.in_region) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_OK;
              cmd.res_hit = 1'b1;
              cmd.res_src = SRC_ENTRY;
              cmd.res_svc = 1'b1;
              state_next = S_FIN;
            end else if (st.base_gt) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_next = S_FIN;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next = S_RD;
            end
          end
          M_EXACT: begin
            if (st.base_eq) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_OK;
              if (st.action == ACT_REMOVE) begin
                cmd.res_src = SRC_ENTRY;
                state_next = S_SDR;
              end else begin
                cmd.res_src = SRC_ENTRY_PROT;
                cmd.wr_prot = 1'b1;
                state_next = S_FIN;
              end
            end else if (st.base_gt) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_next = S_FIN;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next = S_RD;
            end
          end
          default: begin
            if (st.rng_behind) begin
              cmd.idx_inc = 1'b1;
              state_next = S_RD;
            end else if (st.rng_hole || !st.rng_prot_ok) begin
              cmd.res_wr = 1'b1;
              cmd.res_status = ST_OK;
              state_next = S_FIN;
            end else begin
              cmd.cur_rend = 1'b1;
              if (st.rng_done) begin
                cmd.res_wr = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_hit = 1'b1;
                state_next = S_FIN;
              end else begin
                cmd.idx_inc = 1'b1;
                state_next = S_RD;
              end
            end
          end
        endcase
      end
      S_SUR: begin
        if (st.idx_at_pos) begin
          cmd.wr_new = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.res_wr = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_src = SRC_KEY;
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = S_SUW;
        end
      end
      S_SUW: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec = 1'b1;
        state_next = S_SUR;
      end
      S_SDR: begin
        if (st.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.rd = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_next = S_SDW;
        end
      end
      S_SDW: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = S_SDR;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (tail) begin
      if (st.tail_fit) begin
        found = 1'b1;
      end else begin
        cmd.res_wr = 1'b1;
        cmd.res_status = ST_NOSPACE;
        state_next = S_FIN;
      end
    end
    if (found) begin
      cmd.key_cur = 1'b1;
      if (st.full) begin
        cmd.res_wr = 1'b1;
        cmd.res_status = ST_FULL;
        state_next = S_FIN;
      end else begin
        cmd.idx_clr = 1'b1;
        cmd.pos_init = 1'b1;
        mode_next = M_OVL;
        state_next = S_RD;
      end
    end
  end

endmodule

FILE: rtl/vrt_datapath.sv
module vrt_datapath import vrt_pkg::*; #(
  parameter int MAX_REGIONS = 64
) (
  input  logic      clk,
  input  logic      rst,
  vrt_req_if.sink   req,
  vrt_rsp_if.source rsp,
  vrt_cfg_if.sink   cfg,
  input  cmd_t      cmd,
  output st_t       st
);

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  logic [PW-1:0] gen_lo, gen_hi, near_lo, near_hi;

  logic [2:0]    act;
  logic [PW-1:0] key_base, key_pages;
  logic [2:0]    key_prot;
  logic          key_kind, key_gb, key_ga, key_near, key_present;
  logic [1:0]    key_acc;

  logic [CW-1:0] idx, pos, count;
  logic          pos_set;
  logic [EW-1:0] cursor;

  logic [2:0]    res_status;
  logic          res_hit, res_kind, res_svc;
  logic [PW-1:0] res_base, res_pages;
  logic [2:0]    res_prot;

  logic          out_valid;

  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;
  logic               we;
  logic [AW-1:0]      raddr;
  logic [CW-1:0]      idx_prev, idx_next;
  entry_t             ent, ent_prot, ent_new;

  logic [EW-1:0] e_end, rhi, key_hi, need, rng_end, win_lo_x, win_hi_x, rlo_x;
  logic [PW-1:0] rlo, key_lo, win_lo, win_hi;
  logic [2:0]    need_mask;
  logic          svc;

  assign ent = entry_t'(rdata);
  assign e_end = {1'b0, ent.base} + {1'b0, ent.pages};
  assign rlo = ent.base - PW'(ent.attr.gb);
  assign rlo_x = {1'b0, rlo};
  assign rhi = e_end + EW'(ent.attr.ga);
  assign key_lo = key_base - PW'(key_gb);
  assign key_hi = {1'b0, key_base} + {1'b0, key_pages} + EW'(key_ga);
  assign need = {1'b0, key_pages} + EW'(key_gb) + EW'(key_ga);
  assign rng_end = {1'b0, key_base} + {1'b0, key_pages};
  assign win_lo = key_near ? near_lo : gen_lo;
  assign win_hi = key_near ? near_hi : gen_hi;
  assign win_lo_x = {1'b0, win_lo};
  assign win_hi_x = {1'b0, win_hi};
  assign need_mask = key_acc[0] ? 3'b010 : (key_acc[1] ? 3'b100 : 3'b001);
  assign svc = ent.attr.kind && !key_present && (|(ent.attr.prot & need_mask));

  assign idx_prev = idx - CW'(1);
  assign idx_next = idx + CW'(1);

  always_comb begin
    ent_prot = ent;
    ent_prot.attr.prot = key_prot;
    ent_new.base = key_base;
    ent_new.pages = key_pages;
    ent_new.attr = '{ga: key_ga, gb: key_gb, kind: key_kind, prot: key_prot};
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: raddr = idx_prev[AW-1:0];
      RD_NEXT: raddr = idx_next[AW-1:0];
      default: raddr = idx[AW-1:0];
    endcase
  end

  assign we = cmd.wr_shift || cmd.wr_new || cmd.wr_prot;
  assign wdata = cmd.wr_new ? ent_new : (cmd.wr_prot ? ent_prot : rdata);

  vrt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_REGIONS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(idx[AW-1:0]),
    .wdata(wdata),
    .re   (cmd.rd),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    st = '0;
    st.in_valid = req.valid;
    st.action = act;
    st.cnt_zero = (key_pages == '0);
    case (act)
      ACT_INSERT: st.pre_bad = st.cnt_zero || (key_base == '0 && key_gb) ||
                               (key_hi > PAGE_LIMIT);
      ACT_ALLOC: st.pre_bad = st.cnt_zero || (key_prot == 3'd0);
      ACT_SETPROT: st.pre_bad = (key_prot == 3'd0) || (key_prot[2:1] == 2'b11);
      default: st.pre_bad = 1'b0;
    endcase
    st.full = (count == CW'(MAX_REGIONS));
    st.idx_at_count = (idx == count);
    st.idx_at_pos = (idx == pos);
    st.idx_last = (idx_next == count);
    st.ovl = ({1'b0, key_lo} < rhi) && (rlo_x < key_hi);
    st.base_gt = (ent.base > key_base);
    st.base_eq = (ent.base == key_base);
    st.in_region = (key_base >= ent.base) && ({1'b0, key_base} < e_end);
    st.gap_below = (rhi <= win_lo_x);
    st.gap_above = (rlo >= win_hi);
    st.gap_fit = (rlo_x >= cursor) && ((rlo_x - cursor) >= need);
    st.tail_fit = (cursor < win_hi_x) && ((win_hi_x - cursor) >= need);
    st.rng_behind = (e_end <= cursor);
    st.rng_hole = ({1'b0, ent.base} > cursor);
    st.rng_prot_ok = ((ent.attr.prot & key_prot) == key_prot);
    st.rng_done = (e_end >= rng_end);
    st.out_free = !out_valid || rsp.ready;
  end

  assign req.ready = cmd.idle;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_lo <= ARENA_LO_RESET;
      gen_hi <= ARENA_HI_RESET;
      near_lo <= '0;
      near_hi <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ARENA_LO: gen_lo <= cfg.data;
        CFG_ARENA_HI: gen_hi <= cfg.data;
        CFG_NEAR_LO:  near_lo <= cfg.data;
        CFG_NEAR_HI:  near_hi <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= req.action;
      key_base <= req.page_addr;
      key_pages <= req.page_count;
      key_prot <= req.prot;
      key_kind <= req.region_kind;
      key_gb <= req.guard_below;
      key_ga <= req.guard_above;
      key_near <= req.near_window;
      key_acc <= req.access_kind;
      key_present <= req.fault_present;
    end else if (cmd.key_cur) begin
      key_base <= cursor[PW-1:0] + PW'(key_gb);
    end

    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_next;
    end else if (cmd.idx_dec) begin
      idx <= idx_prev;
    end else if (cmd.idx_count) begin
      idx <= count;
    end

    if (cmd.pos_init) begin
      pos <= count;
    end else if (cmd.pos_take && !pos_set) begin
      pos <= idx;
    end

    if (cmd.cur_win) begin
      cursor <= win_lo_x;
    end else if (cmd.cur_addr) begin
      cursor <= {1'b0, key_base};
    end else if (cmd.cur_gap) begin
      cursor <= (rhi > cursor) ? rhi : cursor;
    end else if (cmd.cur_rend) begin
      cursor <= e_end;
    end

    if (cmd.res_wr) begin
      res_status <= cmd.res_status;
      res_hit <= cmd.res_hit;
      res_svc <= cmd.res_svc && svc;
      case (cmd.res_src)
        SRC_KEY: begin
          res_base <= key_base;
          res_pages <= key_pages;
          res_prot <= key_prot;
          res_kind <= key_kind;
        end
        SRC_ENTRY: begin
          res_base <= ent.base;
          res_pages <= ent.pages;
          res_prot <= ent.attr.prot;
          res_kind <= ent.attr.kind;
        end
        SRC_ENTRY_PROT: begin
          res_base <= ent.base;
          res_pages <= ent.pages;
          res_prot <= key_prot;
          res_kind <= ent.attr.kind;
        end
        default: begin
          res_base <= '0;
          res_pages <= '0;
          res_prot <= '0;
          res_kind <= 1'b0;
        end
      endcase
    end

    if (cmd.publish) begin
      rsp.status <= res_status;
      rsp.hit <= res_hit;
      rsp.region_base <= res_base;
      rsp.region_pages <= res_pages;
      rsp.region_prot <= res_prot;
      rsp.found_kind <= res_kind;
      rsp.service_fault <= res_svc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pos_set <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.pos_init) begin
        pos_set <= 1'b0;
      end else if (cmd.pos_take) begin
        pos_set <= 1'b1;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;

endmodule

FILE: rtl/va_region_table_engine.sv
// Sorted table of address regions with first-fit allocation.
// Requests arrive on req and each gives exactly one transaction on rsp. The
// cfg channel writes the four window registers and is always ready; the user
// must see that it is written only while the block is idle; the block itself
// does not enforce this. One request is worked on at a time. Every table
// entry that a request visits is read from the table memory and then
// evaluated. An insert scans the table for overlaps and then moves each
// entry above the new one up, with a read and then a write; an allocation
// scans for a gap first.
// The result is held in an output register; a new request is accepted while
// it waits, but the next result is not presented until the receiver has taken
// the previous one, and the block stalls until then.
// Reset empties the table and loads the default windows; no clearing pass
// is needed.
module va_region_table_engine import vrt_pkg::*; #(
  parameter int MAX_REGIONS = 64
) (
  input  logic      clk,
  input  logic      rst,
  vrt_req_if.sink   req,
  vrt_rsp_if.source rsp,
  vrt_cfg_if.sink   cfg
);

  cmd_t cmd;
  st_t  st;

  vrt_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .st (st),
    .cmd(cmd)
  );

  vrt_datapath #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg),
    .cmd(cmd),
    .st (st)
  );

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !st.full)
    else $error("entry added to a full table");

  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> st.out_free)
    else $error("result overwritten before it was taken");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  a_insert_at_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_new |-> st.idx_at_pos)
    else $error("new entry written away from its sorted position");

endmodule

FILE: dv/tb_top.sv
module tb_top import vrt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREG = 64;
  localparam logic [EW-1:0] PLIM = PAGE_LIMIT;

  typedef struct packed {
    logic [2:0]    status;
    logic          hit;
    logic [PW-1:0] base;
    logic [PW-1:0] pages;
    logic [2:0]    prot;
    logic          kind;
    logic          svc;
  } outcome_t;

  typedef struct {
    logic [PW-1:0] base;
    logic [PW-1:0] pages;
    attr_t         attr;
  } region_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vrt_req_if req ();
  vrt_rsp_if rsp ();
  vrt_cfg_if cfg ();

  va_region_table_engine #(.MAX_REGIONS(NREG)) DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  region_t       regions[$];
  logic [PW-1:0] win_gen_lo = ARENA_LO_RESET;
  logic [PW-1:0] win_gen_hi = ARENA_HI_RESET;
  logic [PW-1:0] win_near_lo = '0;
  logic [PW-1:0] win_near_hi = '0;
  outcome_t      pending_outcomes[$];
  int            mismatches = 0;
  bit            calm = 0;

  function automatic logic [EW-1:0] fp_lo(region_t r);
    return {1'b0, r.base} - r.attr.gb;
  endfunction

  function automatic logic [EW-1:0] fp_hi(region_t r);
    return {1'b0, r.base} + r.pages + r.attr.ga;
  endfunction

  function automatic int exact_index(logic [PW-1:0] b);
    foreach (regions[i]) begin
      if (regions[i].base == b) return i;
      if (regions[i].base > b) break;
    end
    return -1;
  endfunction

  function automatic logic [2:0] place_region(region_t n);
    logic [EW-1:0] lo, hi;
    int pos;
    lo = fp_lo(n);
    hi = fp_hi(n);
    if (regions.size() >= NREG) return ST_FULL;
    foreach (regions[i])
      if (lo < fp_hi(regions[i]) && fp_lo(regions[i]) < hi) return ST_OVERLAP;
    pos = regions.size();
    foreach (regions[i])
      if (regions[i].base > n.base) begin
        pos = i;
        break;
      end
    regions.insert(pos, n);
    return ST_OK;
  endfunction

  function automatic bit first_fit(logic [PW-1:0] wlo, logic [PW-1:0] whi,
                                   logic [EW-1:0] need, output logic [EW-1:0] at);
    logic [EW-1:0] cursor, lo, hi;
    cursor = {1'b0, wlo};
    foreach (regions[i]) begin
      lo = fp_lo(regions[i]);
      hi = fp_hi(regions[i]);
      if (hi <= wlo) continue;
      if (lo >= whi) break;
      if (lo >= cursor && lo - cursor >= need) begin
        at = cursor;
        return 1;
      end
      if (hi > cursor) cursor = hi;
    end
    if (cursor < whi && whi - cursor >= need) begin
      at = cursor;
      return 1;
    end
    return 0;
  endfunction

  function automatic void describe(inout outcome_t o, input int i);
    o.base = regions[i].base;
    o.pages = regions[i].pages;
    o.prot = regions[i].attr.prot;
    o.kind = regions[i].attr.kind;
  endfunction

  function automatic outcome_t table_outcome(
      logic [2:0] act, logic [PW-1:0] addr, logic [PW-1:0] cnt, logic [2:0] pr,
      logic kd, logic gb, logic ga, logic nw, logic [1:0] acc, logic present);
    outcome_t o;
    region_t n;
    logic [EW-1:0] at, cursor, stop, rend;
    logic [2:0] need;
    int idx;
    o = '0;
    o.status = ST_INVALID;
    n.base = addr;
    n.pages = cnt;
    n.attr = '{ga: ga, gb: gb, kind: kd, prot: pr};
    case (act)
      ACT_INSERT: begin
        if (cnt != 0 && addr >= gb && {1'b0, addr} + cnt + ga <= PLIM) begin
          o.status = place_region(n);
          if (o.status == ST_OK) describe(o, exact_index(addr));
        end
      end
      ACT_ALLOC: begin
        if (cnt != 0 && pr != 0) begin
          if (!(nw ? first_fit(win_near_lo, win_near_hi, {1'b0, cnt} + gb + ga, at)
                   : first_fit(win_gen_lo, win_gen_hi, {1'b0, cnt} + gb + ga, at))) begin
            o.status = ST_NOSPACE;
          end else begin
            n.base = at[PW-1:0] + gb;
            o.status = place_region(n);
            if (o.status == ST_OK) describe(o, exact_index(n.base));
          end
        end
      end
      ACT_LOOKUP: begin
        o.status = ST_NOTFOUND;
        foreach (regions[i]) begin
          if (addr >= regions[i].base && {1'b0, addr} < {1'b0, regions[i].base} + regions[i].pages) begin
            need = acc[0] ? 3'd2 : acc[1] ? 3'd4 : 3'd1;
            o.status = ST_OK;
            o.hit = 1'b1;
            describe(o, i);
            o.svc = regions[i].attr.kind && !present && ((regions[i].attr.prot & need) != 0);
            break;
          end
          if (regions[i].base > addr) break;
        end
      end
      ACT_REMOVE: begin
        idx = exact_index(addr);
        if (idx < 0) o.status = ST_NOTFOUND;
        else begin
          describe(o, idx);
          regions.delete(idx);
          o.status = ST_OK;
        end
      end
      ACT_SETPROT: begin
        if (pr != 0 && pr[2:1] != 2'b11) begin
          idx = exact_index(addr);
          if (idx < 0) o.status = ST_NOTFOUND;
          else begin
            regions[idx].attr.prot = pr;
            describe(o, idx);
            o.status = ST_OK;
          end
        end
      end
      ACT_RANGE: begin
        o.status = ST_OK;
        cursor = {1'b0, addr};
        stop = {1'b0, addr} + cnt;
        if (cnt == 0) o.hit = 1'b1;
        else
          foreach (regions[i]) begin
            rend = {1'b0, regions[i].base} + regions[i].pages;
            if (rend <= cursor) continue;
            if (regions[i].base > cursor) break;
            if ((regions[i].attr.prot & pr) != pr) break;
            cursor = rend;
            if (cursor >= stop) begin
              o.hit = 1'b1;
              break;
            end
          end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [PW-1:0] got, logic [PW-1:0] want);
    mismatches++;
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
  endtask

  function automatic bit idle_now();
    return !calm && $urandom_range(99) < 26;
  endfunction

  task automatic send_item(logic [2:0] act, logic [PW-1:0] addr, logic [PW-1:0] cnt,
                           logic [2:0] pr, logic kd, logic gb, logic ga, logic nw,
                           logic [1:0] acc, logic present);
    while (idle_now()) @(posedge clk);
    req.valid <= 1'b1;
    req.action <= act;
    req.page_addr <= addr;
    req.page_count <= cnt;
    req.prot <= pr;
    req.region_kind <= kd;
    req.guard_below <= gb;
    req.guard_above <= ga;
    req.near_window <= nw;
    req.access_kind <= acc;
    req.fault_present <= present;
    do @(posedge clk); while (!req.ready);
    pending_outcomes.push_back(table_outcome(act, addr, cnt, pr, kd, gb, ga, nw, acc, present));
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (pending_outcomes.size() == 0) report_mismatch("unexpected transaction", 0, 0);
        else begin
          want = pending_outcomes.pop_front();
          if (rsp.status !== want.status) report_mismatch("status", rsp.status, want.status);
          if (rsp.hit !== want.hit) report_mismatch("hit", rsp.hit, want.hit);
          if (rsp.region_base !== want.base) report_mismatch("region_base", rsp.region_base, want.base);
          if (rsp.region_pages !== want.pages)
            report_mismatch("region_pages", rsp.region_pages, want.pages);
          if (rsp.region_prot !== want.prot) report_mismatch("region_prot", rsp.region_prot, want.prot);
          if (rsp.found_kind !== want.kind) report_mismatch("found_kind", rsp.found_kind, want.kind);
          if (rsp.service_fault !== want.svc)
            report_mismatch("service_fault", rsp.service_fault, want.svc);
        end
      end
      rsp.ready <= !idle_now();
    end else begin
      rsp.ready <= 1'b0;
    end
  end

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_outcomes.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_window(logic [1:0] idx, logic [PW-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_ARENA_LO: win_gen_lo = value;
      CFG_ARENA_HI: win_gen_hi = value;
      CFG_NEAR_LO: win_near_lo = value;
      default: win_near_hi = value;
    endcase
    @(posedge clk);
  endtask

  task automatic set_windows(logic [PW-1:0] alo, logic [PW-1:0] ahi,
                             logic [PW-1:0] nlo, logic [PW-1:0] nhi);
    drain();
    write_window(CFG_ARENA_LO, alo);
    write_window(CFG_ARENA_HI, ahi);
    write_window(CFG_NEAR_LO, nlo);
    write_window(CFG_NEAR_HI, nhi);
  endtask

  task automatic empty_table();
    while (regions.size() != 0)
      send_item(ACT_REMOVE, regions[0].base, 0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  localparam logic [PW-1:0] TOP = {PW{1'b1}};

  task automatic test_directed();
    send_item(ACT_INSERT, 100, 0, 3'd1, 0, 0, 0, 0, 0, 0);
    send_item(ACT_INSERT, 0, 4, 3'd1, 0, 1, 0, 0, 0, 0);
    send_item(ACT_INSERT, TOP, 1, 3'd1, 0, 0, 1, 0, 0, 0);
    send_item(ACT_INSERT, TOP, 1, 3'd7, 1, 0, 0, 0, 0, 0);
    send_item(ACT_INSERT, 0, 16, 3'd3, 1, 0, 1, 0, 0, 0);
    send_item(ACT_INSERT, 16, 4, 3'd1, 0, 0, 0, 0, 0, 0);
    send_item(ACT_INSERT, 18, 4, 3'd5, 0, 1, 0, 0, 0, 0);
    send_item(ACT_ALLOC, 0, 8, 3'd0, 1, 0, 0, 0, 0, 0);
    send_item(ACT_ALLOC, 0, 0, 3'd3, 1, 0, 0, 0, 0, 0);
    send_item(ACT_ALLOC, 0, 8, 3'd3, 1, 1, 1, 0, 0, 0);
    send_item(ACT_ALLOC, 0, 8, 3'd3, 1, 1, 1, 1, 0, 0);
    send_item(ACT_LOOKUP, 5, 0, 0, 0, 0, 0, 0, 2'd3, 0);
    send_item(ACT_LOOKUP, 5, 0, 0, 0, 0, 0, 0, 2'd2, 0);
    send_item(ACT_LOOKUP, 5, 0, 0, 0, 0, 0, 0, 2'd1, 1);
    send_item(ACT_LOOKUP, 16, 0, 0, 0, 0, 0, 0, 2'd0, 0);
    send_item(ACT_SETPROT, 0, 0, 3'd6, 0, 0, 0, 0, 0, 0);
    send_item(ACT_SETPROT, 0, 0, 3'd0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_SETPROT, 0, 0, 3'd5, 0, 0, 0, 0, 0, 0);
    send_item(ACT_SETPROT, 7, 0, 3'd1, 0, 0, 0, 0, 0, 0);
    send_item(ACT_RANGE, 3, 0, 3'd7, 0, 0, 0, 0, 0, 0);
    send_item(ACT_RANGE, 0, 20, 3'd1, 0, 0, 0, 0, 0, 0);
    send_item(ACT_RANGE, TOP, TOP, 3'd1, 0, 0, 0, 0, 0, 0);
    send_item(ACT_REMOVE, 7, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(3'd6, TOP, TOP, 3'd7, 1, 1, 1, 1, 2'd3, 1);
    send_item(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    empty_table();
  endtask

  function automatic logic [PW-1:0] pick_page(logic [PW-1:0] base);
    if ($urandom_range(19) == 0) return PW'({$urandom, $urandom});
    return base + $urandom_range(300);
  endfunction

  task automatic test_random(int items, logic [PW-1:0] base);
    logic [2:0] act;
    logic [PW-1:0] addr, cnt;
    int r;
    repeat (items) begin
      r = $urandom_range(99);
      act = r < 22 ? ACT_INSERT : r < 42 ? ACT_ALLOC : r < 62 ? ACT_LOOKUP :
            r < 76 ? ACT_REMOVE : r < 87 ? ACT_SETPROT : r < 98 ? ACT_RANGE : 3'(6 + r % 2);
      addr = pick_page(base);
      if ((act == ACT_REMOVE || act == ACT_SETPROT || act == ACT_LOOKUP) &&
          regions.size() != 0 && $urandom_range(3) != 0)
        addr = regions[$urandom_range(regions.size() - 1)].base;
      cnt = $urandom_range(99) < 3 ? PW'({$urandom, $urandom}) : PW'($urandom_range(24));
      send_item(act, addr, cnt, 3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                1'($urandom), 2'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_fill_table();
    repeat (NREG + 3) send_item(ACT_ALLOC, 0, 1, 3'd1, 0, 0, 0, 1, 0, 0);
    send_item(ACT_INSERT, TOP - 1, 1, 3'd1, 0, 0, 0, 0, 0, 0);
    empty_table();
  endtask

  initial begin
    req.valid = 1'b0;
    req.action = '0;
    req.page_addr = '0;
    req.page_count = '0;
    req.prot = '0;
    req.region_kind = 1'b0;
    req.guard_below = 1'b0;
    req.guard_above = 1'b0;
    req.near_window = 1'b0;
    req.access_kind = '0;
    req.fault_present = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_windows(ARENA_LO_RESET, ARENA_LO_RESET + 200, 0, 80);
    test_random(400, ARENA_LO_RESET - 20);
    calm = 1;
    test_random(150, 0);
    calm = 0;
    set_windows(TOP - 120, TOP, 40, 30);
    empty_table();
    test_random(400, TOP - 300);
    set_windows(0, TOP, 0, 200);
    empty_table();
    test_fill_table();
    set_windows(0, 0, 1000, 1000);
    test_random(300, 900);
    set_windows(ARENA_LO_RESET, ARENA_HI_RESET, 0, 0);
    test_random(250, ARENA_LO_RESET);
    drain();
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/vrt_pkg.sv
rtl/vrt_if.sv
rtl/vrt_ram.sv
rtl/vrt_ctrl.sv
rtl/vrt_datapath.sv
rtl/va_region_table_engine.sv
dv/tb_top.sv
